// ===== rtl/life_grid_neighbor_query_top_defines.svh =====
// Assertion macros used by the checker file.
`ifndef LIFE_GRID_NEIGHBOR_QUERY_TOP_DEFINES_SVH
`define LIFE_GRID_NEIGHBOR_QUERY_TOP_DEFINES_SVH

// Same-cycle implication, muted during reset.
`define LGNQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted during reset.
`define LGNQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lgnq_pkg.sv =====
package lgnq_pkg;

  // Grid geometry
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int X_W        = $clog2(MAX_WIDTH);
  localparam int Y_W        = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = X_W + Y_W;
  localparam int CELL_W     = 2;
  localparam int DIM_W      = 7;
  localparam int CNT_W      = 4;
  localparam int NBR_W      = 3;

  localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

  // Register indexes
  localparam logic REG_BOARD_WIDTH  = 1'b0;
  localparam logic REG_BOARD_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    CMD_QUERY       = 2'd0,
    CMD_WRITE_ALIVE = 2'd1,
    CMD_WRITE_LIVE  = 2'd2,
    CMD_READ        = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_UPD,
    ST_NBR,
    ST_NBR_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 we;
    logic [ADDR_W-1:0]    wr_addr;
    logic [CELL_W-1:0]    wr_data;
  } mem_req_t;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_W-1:0]    addr;
  } nbr_t;

  typedef struct packed {
    logic                 bad_coord;
    logic                 to_live;
    logic                 alive;
    logic [CNT_W-1:0]     neighbor_count;
    logic                 has_count;
  } result_t;

  // Column offset of neighbor k, row-major around the center
  function automatic logic signed [1:0] nbr_dx(input logic [NBR_W-1:0] k);
    case (k)
      3'd0, 3'd3, 3'd5: nbr_dx = -2'sd1;
      3'd1, 3'd6:       nbr_dx = 2'sd0;
      default:          nbr_dx = 2'sd1;
    endcase
  endfunction

  // Row offset of neighbor k
  function automatic logic signed [1:0] nbr_dy(input logic [NBR_W-1:0] k);
    case (k)
      3'd0, 3'd1, 3'd2: nbr_dy = -2'sd1;
      3'd3, 3'd4:       nbr_dy = 2'sd0;
      default:          nbr_dy = 2'sd1;
    endcase
  endfunction

endpackage

// ===== rtl/lgnq_cell_ram.sv =====
module lgnq_cell_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 2
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/lgnq_nbr_gen.sv =====
module lgnq_nbr_gen
  import lgnq_pkg::*;
(
  input  logic [X_W-1:0]   x,
  input  logic [Y_W-1:0]   y,
  input  logic [NBR_W-1:0] k,
  input  logic [DIM_W-1:0] used_w,
  input  logic [DIM_W-1:0] used_h,
  output nbr_t             nbr
);

  logic signed [X_W+1:0] nx;
  logic signed [Y_W+1:0] ny;

  // Offset the center; the top bit marks a step off the low edge
  assign nx = $signed({2'b00, x}) + (X_W+2)'(nbr_dx(k));
  assign ny = $signed({2'b00, y}) + (Y_W+2)'(nbr_dy(k));

  // Skip neighbors outside the board in use
  assign nbr.valid = !nx[X_W+1] && !ny[Y_W+1] &&
                     (DIM_W'(nx[X_W:0]) < used_w) &&
                     (DIM_W'(ny[Y_W:0]) < used_h);
  assign nbr.addr  = {ny[Y_W-1:0], nx[X_W-1:0]};

endmodule

// ===== rtl/lgnq_ctrl.sv =====
module lgnq_ctrl
  import lgnq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [DIM_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_cmd,
  input  logic [X_W-1:0]    in_x,
  input  logic [Y_W-1:0]    in_y,
  input  logic              in_flag,
  input  logic [CNT_W-1:0]  in_target,
  output logic              out_valid,
  input  logic              out_ready,
  output result_t           out_res,
  output mem_req_t          mem_req,
  input  logic [CELL_W-1:0] mem_rd_data
);

  state_t              state, state_next;
  logic [DIM_W-1:0]    board_w, board_h;
  logic [DIM_W-1:0]    used_w, used_h;
  logic [ADDR_W-1:0]   clr_addr;
  logic [NBR_W-1:0]    k;
  logic                pend;
  logic [CNT_W-1:0]    count;
  logic [CELL_W-1:0]   cell_bits;
  cmd_t                cmd;
  logic [X_W-1:0]      x;
  logic [Y_W-1:0]      y;
  logic                flag;
  logic [CNT_W-1:0]    target;
  logic                bad;
  logic                in_bad;
  logic                accept;
  logic                load_out;
  nbr_t                nbr;
  result_t             res_next;

  // Clip the board to the grid size
  assign used_w = (board_w > MAX_W_DIM) ? MAX_W_DIM : board_w;
  assign used_h = (board_h > MAX_H_DIM) ? MAX_H_DIM : board_h;

  assign in_bad = (DIM_W'(in_x) >= used_w) || (DIM_W'(in_y) >= used_h);
  assign accept = in_valid && in_ready;

  lgnq_nbr_gen u_nbr_gen (
    .x      (x),
    .y      (y),
    .k      (k),
    .used_w (used_w),
    .used_h (used_h),
    .nbr    (nbr)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      board_w <= MAX_W_DIM;
      board_h <= MAX_H_DIM;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOARD_WIDTH:  board_w <= cfg_data;
        REG_BOARD_HEIGHT: board_h <= cfg_data;
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory requests, handshakes
  always_comb begin
    state_next      = state;
    in_ready        = 1'b0;
    load_out        = 1'b0;
    mem_req.rd_en   = 1'b0;
    mem_req.rd_addr = {y, x};
    mem_req.we      = 1'b0;
    mem_req.wr_addr = {y, x};
    mem_req.wr_data = mem_rd_data;
    case (state)
      ST_CLEAR: begin
        mem_req.we      = 1'b1;
        mem_req.wr_addr = clr_addr;
        mem_req.wr_data = '0;
        if (&clr_addr) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_bad) begin
            state_next = ST_DONE;
          end else if (cmd_t'(in_cmd) == CMD_QUERY) begin
            state_next = ST_NBR;
          end else begin
            state_next = ST_CELL_RD;
          end
        end
      end
      ST_CELL_RD: begin
        mem_req.rd_en = 1'b1;
        state_next    = ST_CELL_UPD;
      end
      ST_CELL_UPD: begin
        case (cmd)
          CMD_WRITE_ALIVE: begin
            mem_req.we      = 1'b1;
            mem_req.wr_data = {mem_rd_data[1], flag};
          end
          CMD_WRITE_LIVE: begin
            mem_req.we      = 1'b1;
            mem_req.wr_data = {flag, mem_rd_data[0]};
          end
          default: ;
        endcase
        state_next = ST_DONE;
      end
      ST_NBR: begin
        mem_req.rd_en   = nbr.valid;
        mem_req.rd_addr = nbr.addr;
        if (&k) begin
          state_next = ST_NBR_DRAIN;
        end
      end
      ST_NBR_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sweep the grid clear after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Latch the item and walk the neighbors
  always_ff @(posedge clk) begin
    if (rst) begin
      k     <= '0;
      pend  <= 1'b0;
      count <= '0;
    end else begin
      if (accept) begin
        k     <= '0;
        pend  <= 1'b0;
        count <= '0;
      end
      if (state == ST_NBR) begin
        k    <= k + 1'b1;
        pend <= nbr.valid;
      end
      if ((state == ST_NBR || state == ST_NBR_DRAIN) && pend) begin
        count <= count + CNT_W'(mem_rd_data[0]);
      end
      if (state == ST_NBR_DRAIN) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd       <= cmd_t'(in_cmd);
      x         <= in_x;
      y         <= in_y;
      flag      <= in_flag;
      target    <= in_target;
      bad       <= in_bad;
      cell_bits <= '0;
    end else if (state == ST_CELL_UPD && cmd == CMD_READ) begin
      cell_bits <= mem_rd_data;
    end
  end

  // Build the result; fields outside the command stay zero
  always_comb begin
    res_next                = '0;
    res_next.bad_coord      = bad;
    if (!bad) begin
      case (cmd)
        CMD_QUERY: begin
          res_next.neighbor_count = count;
          res_next.has_count      = (count == target);
        end
        CMD_READ: begin
          res_next.alive   = cell_bits[0];
          res_next.to_live = cell_bits[1];
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res <= res_next;
    end
  end

endmodule

// ===== rtl/life_grid_neighbor_query_top.sv =====
// Life grid neighbor query block.
// Input stream (s_*): one command per beat; s_tuser carries the command, s_tdata
// the coordinate, the bit to write and the target count. Output stream (m_*):
// exactly one result beat per command, in order.
// A cell is addressed as {row, column} in one 4096 x 2 grid memory with one
// read port and one write port and a registered read. A neighbor query walks
// the eight neighbors (ST_NBR), one memory read per cycle for each neighbor on
// the board, then drains the last read (ST_NBR_DRAIN) and loads the output
// register (ST_DONE). A cell write does one read and one write-back; a cell
// read does one read. Off-board coordinates go straight to the output register.
// One command is in work at a time; the next is taken when it ends.
// The result sits in an output register, so a new command is taken while it
// waits; a stalled receiver holds that beat and the next result waits inside.
// Reset (rst, synchronous) sets the board to 64 x 64 and starts a clearing
// sweep of all 4096 cells, one cell per cycle, with s_tready low; configuration
// writes (cfg_we, cfg_index, cfg_data) are taken at any time, write only.
module life_grid_neighbor_query_top
  import lgnq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // x_coord[5:0], y_coord[11:6], flag_value[12],
                                 // target_count[16:13], zero fill
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // has_count[0], neighbor_count[4:1], alive[5],
                                 // to_live[6], zero fill
  output logic        m_tuser    // bad_coord[0]
);

  mem_req_t          mem_req;
  logic [CELL_W-1:0] mem_rd_data;
  result_t           res;

  lgnq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_cmd      (s_tuser),
    .in_x        (s_tdata[X_W-1:0]),
    .in_y        (s_tdata[X_W+Y_W-1:X_W]),
    .in_flag     (s_tdata[X_W+Y_W]),
    .in_target   (s_tdata[X_W+Y_W+CNT_W:X_W+Y_W+1]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_res     (res),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data)
  );

  lgnq_cell_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (CELL_W)
  ) u_cell_ram (
    .clk     (clk),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (mem_rd_data),
    .we      (mem_req.we),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data)
  );

  // Pack the result beat
  assign m_tdata = {1'b0, res.to_live, res.alive, res.neighbor_count, res.has_count};
  assign m_tuser = res.bad_coord;

endmodule

// ===== rtl/lgnq_checker.sv =====
`include "life_grid_neighbor_query_top_defines.svh"

module lgnq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tuser
);

  logic [8:0] out_beat;
  logic       count_ok;
  logic       fields_apart;

  assign out_beat     = {m_tuser, m_tdata};
  assign count_ok     = (m_tdata[4:1] <= 4'd8);
  assign fields_apart = (m_tdata[6:5] == 2'd0) || (m_tdata[4:0] == 5'd0);

  // One command in work at a time
  `LGNQ_ASSERT_NEXT(a_one_in_work, s_tvalid && s_tready, !s_tready, "command taken while busy")

  // Hold a stalled result beat
  `LGNQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(out_beat), "stalled result changed")

  // Off-board coordinates report nothing else
  `LGNQ_ASSERT_NOW(a_bad_clean, m_tvalid && m_tuser, m_tdata == 8'd0, "off-board result not clean")

  // At most eight neighbors, and query and read fields never mix
  `LGNQ_ASSERT_NOW(a_count_range, m_tvalid, count_ok && fields_apart, "bad result fields")

endmodule

bind life_grid_neighbor_query_top lgnq_checker u_checker (.*);
